### rtl/nms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_pkg
// Shared constants, register map and pipeline structs for the edge
// non-maximum suppression core.
// ----------------------------------------------------------------------------
package nms_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  // Line word: {prev2 magnitude, prev direction, prev magnitude}
  localparam int RAM_W     = 24;

  // Configuration register widths and reset values
  localparam int           WIDTH_W      = 11;
  localparam int           HEIGHT_W     = 16;
  localparam int           CFG_ADDR_W   = 3;
  localparam int           CFG_DATA_W   = 32;
  localparam logic [10:0]  WIDTH_RESET  = 11'd640;
  localparam logic [15:0]  HEIGHT_RESET = 16'd480;

  // Register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Direction codes
  localparam logic [7:0] DIR_VERT  = 8'd255;
  localparam logic [7:0] DIR_DIAG1 = 8'd63;   // up-right / down-left
  localparam logic [7:0] DIR_HORZ  = 8'd127;
  localparam logic [7:0] DIR_DIAG2 = 8'd191;  // up-left / down-right
  localparam logic [7:0] MAG_SAT   = 8'd255;

  // Result buffer depth
  localparam int OUT_DEPTH = 3;

  // Pixel moving from the address stage to the window stage
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic [7:0]       mag;
    logic [7:0]       dir;
    logic [COL_W-1:0] addr;
  } nms_pix_t;

  // Result moving from the window stage to the output buffer
  typedef struct packed {
    logic       valid;
    logic [7:0] edge_value;
    logic       last;
  } nms_res_t;

endpackage

### rtl/nms_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_line_ram
// Single-port-read, single-port-write line store with registered read data.
// ----------------------------------------------------------------------------
module nms_line_ram
  import nms_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output logic [RAM_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [RAM_W-1:0] wr_data
);

  logic [RAM_W-1:0] mem [MAX_WIDTH];
  logic [RAM_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/nms_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_window
// 3x3 magnitude window and direction delay; picks the two neighbors by
// direction code and suppresses the center pixel if it is not a maximum.
// ----------------------------------------------------------------------------
module nms_window
  import nms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  nms_pix_t         pix,
  input  logic [RAM_W-1:0] line_word,
  output nms_res_t         res
);

  // Column word: {bottom, mid, top}
  logic [23:0] win_r [3];
  logic [23:0] win_nxt [3];
  logic [7:0]  dd_r [2];
  logic [7:0]  dd_nxt [2];

  // Shift the window and the direction delay by one column
  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = {pix.mag, line_word[7:0], line_word[23:16]};
    dd_nxt[0]  = line_word[15:8];
    dd_nxt[1]  = dd_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) win_r[i] <= '0;
      dd_r[0] <= '0;
      dd_r[1] <= '0;
    end else if (pix.valid) begin
      for (int i = 0; i < 3; i++) win_r[i] <= win_nxt[i];
      dd_r[0] <= dd_nxt[0];
      dd_r[1] <= dd_nxt[1];
    end
  end

  // Neighbor select and compare on the shifted window
  always_comb begin
    logic [7:0] center;
    logic [7:0] q;
    logic [7:0] r;
    center = win_nxt[1][15:8];
    q      = MAG_SAT;
    r      = MAG_SAT;
    unique case (dd_nxt[1])
      DIR_VERT: begin
        q = win_nxt[1][23:16];
        r = win_nxt[1][7:0];
      end
      DIR_DIAG1: begin
        q = win_nxt[2][7:0];
        r = win_nxt[0][23:16];
      end
      DIR_HORZ: begin
        q = win_nxt[2][15:8];
        r = win_nxt[0][15:8];
      end
      DIR_DIAG2: begin
        q = win_nxt[0][7:0];
        r = win_nxt[2][23:16];
      end
      default: begin
        q = MAG_SAT;
        r = MAG_SAT;
      end
    endcase
    res.valid      = pix.valid && pix.emit;
    res.edge_value = (center >= q && center >= r) ? center : 8'd0;
    res.last       = pix.last;
  end

endmodule

### rtl/nms_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_out_fifo
// Small result buffer in front of the output channel; reserves room for the
// pixel in flight so that no result is lost when the output stalls.
// ----------------------------------------------------------------------------
module nms_out_fifo
  import nms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  nms_res_t   res,
  input  logic       inflight,
  output logic       room,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [8:0]       buf_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]   pend;
  logic             push;
  logic             pop;

  assign push = res.valid;
  assign pop  = out_tvalid && out_tready;

  // Pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= {res.last, res.edge_value};
    end
  end

  // Room for one more pixel counting the one in the window stage
  assign pend = {1'b0, cnt_r} + {{CNT_W{1'b0}}, inflight};
  assign room = pend < (CNT_W + 1)'(OUT_DEPTH);

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[rd_ptr_r][7:0];
  assign out_tlast  = buf_r[rd_ptr_r][8];

endmodule

### rtl/edge_non_max_suppression_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_non_max_suppression_core
// Canny-style non-maximum suppression over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per transfer in raster order, magnitude and direction.
//   out_* : one suppressed magnitude per input pixel from the third row and
//           third column of the frame on; out_tlast marks the frame's final
//           interior pixel. Border pixels produce no transfer.
//   cfg_* : image_width at 0x0, image_height at 0x4. Any write restarts the
//           frame at row 0, column 0; write only while the core is idle.
// Path: an accepted pixel is registered into the window stage, whose result is
//   written into the result buffer; out_tvalid comes from that buffer.
// Throughput: one pixel per cycle while in_tready is high, set by the single
//   line RAM, which is read at the address stage and written back in the
//   following cycle. The same entry is touched again no sooner than three
//   pixels later, so no forwarding is required.
// Stall: a three-entry result buffer absorbs the pixel in flight; in_tready
//   drops when the buffered results plus the pixel in the window stage fill
//   all three entries.
// Reset: counters, window and result buffer clear; the line RAM is not
//   cleared, and entries read before they are written feed no emitted result.
// ----------------------------------------------------------------------------
module edge_non_max_suppression_core
  import nms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input pixels
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [7:0] magnitude, [15:8] direction
  // Results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] edge_value
  output logic                  out_tlast,
  // Configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                cfg_wr;

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [15:0]         row_r, row_nxt;
  logic [COL_W-1:0]    w_last;
  logic [15:0]         h_last;
  logic                col_end;
  logic                row_end;
  logic                in_acc;

  nms_pix_t            pix_r, pix_nxt;
  nms_res_t            res;
  logic [RAM_W-1:0]    line_word;
  logic                room;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[HEIGHT_W-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_IMAGE_WIDTH:  cfg_prdata = {{(CFG_DATA_W - WIDTH_W){1'b0}}, width_r};
      REG_IMAGE_HEIGHT: cfg_prdata = {{(CFG_DATA_W - HEIGHT_W){1'b0}}, height_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Effective frame size minus one, clamped
  always_comb begin
    if (width_r < WIDTH_W'(3)) begin
      w_last = COL_W'(2);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(width_r - 1'b1);
    end
    h_last = (height_r < HEIGHT_W'(3)) ? 16'd2 : height_r - 1'b1;
  end

  // Address stage: raster position and line RAM read
  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;
  assign col_end   = (col_r >= w_last);
  assign row_end   = (row_r >= h_last);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? 16'd0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    pix_nxt.valid = in_acc;
    pix_nxt.emit  = (col_r >= COL_W'(2)) && (row_r >= 16'd2);
    pix_nxt.last  = col_end && row_end;
    pix_nxt.mag   = in_tdata[7:0];
    pix_nxt.dir   = in_tdata[15:8];
    pix_nxt.addr  = col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pix_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pix_r <= pix_nxt;
    end
  end

  // Line store: read at the address stage, written back at the window stage
  nms_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (line_word),
    .wr_en   (pix_r.valid),
    .wr_addr (pix_r.addr),
    .wr_data ({line_word[7:0], pix_r.dir, pix_r.mag})
  );

  // Window stage
  nms_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (pix_r),
    .line_word (line_word),
    .res       (res)
  );

  // Result buffer
  nms_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .inflight   (pix_r.valid),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/nms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_checker
// Port-level checks for the edge non-maximum suppression core.
// ----------------------------------------------------------------------------
module nms_checker
  import nms_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [7:0]            out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  logic width_wr;
  assign width_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                    (cfg_paddr[2] == REG_IMAGE_WIDTH);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result offered right after reset");

  // Empty buffer and nothing in flight: input must be ready
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_tvalid && !$past(in_tvalid && in_tready) |-> in_tready)
    else $error("input stalled while core is empty");

  // A width write reads back
  a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
    $past(width_wr) && $past(rst_n) && (cfg_paddr[2] == REG_IMAGE_WIDTH)
      |-> cfg_prdata[WIDTH_W-1:0] == $past(cfg_pwdata[WIDTH_W-1:0]))
    else $error("image_width readback mismatch");

endmodule

bind edge_non_max_suppression_core nms_checker u_nms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tlast   (out_tlast),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);
